@@ rtl/core/ilp_pkg.sv @@
// Shared types, character codes and digit decoding for the integer literal parser.
// Depends on nothing; used by the parser core and its port checker.
`timescale 1ns / 1ps

package ilp_pkg;

   // One character of a token, with the end-of-token flag
   typedef struct packed {
      logic [7:0] char_in;
      logic       last_char;
   } req_payload_type;

   // One parse result
   typedef struct packed {
      logic        parse_ok;
      logic [63:0] parsed_value;
   } rsp_payload_type;

   localparam int unsigned VALUE_W = 64;
   localparam int unsigned HALF_W  = VALUE_W / 2;
   localparam int unsigned BASE_W  = 5;

   localparam logic [BASE_W-1:0] BASE_DECIMAL = 5'd10;

   // Accumulator path indexes
   localparam int unsigned PATH_DEF = 0;
   localparam int unsigned PATH_BIN = 1;
   localparam int unsigned PATH_OCT = 2;
   localparam int unsigned PATH_HEX = 3;
   localparam int unsigned NUM_PATHS = 4;

   // Character codes
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_LOWER_B = 8'h62;
   localparam logic [7:0] CHAR_LOWER_O = 8'h6F;
   localparam logic [7:0] CHAR_LOWER_H = 8'h68;
   localparam logic [7:0] CHAR_LOWER_X = 8'h78;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   // Digit value of a character; bit 4 set means not a hex digit
   function automatic logic [4:0] digit_of(input logic [7:0] c);
      logic [4:0] d;
      d = 5'h10;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d = {1'b0, 4'(c - CHAR_ZERO)};
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         d = {1'b0, 4'(c - CHAR_LOWER_A + 8'd10)};
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         d = {1'b0, 4'(c - CHAR_UPPER_A + 8'd10)};
      end
      return d;
   endfunction

   // Fold upper case letters to lower case
   function automatic logic [7:0] lower_of(input logic [7:0] c);
      logic [7:0] l;
      l = c;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         l = c + CASE_OFFSET;
      end
      return l;
   endfunction

endpackage

@@ rtl/core/integer_literal_parser_core.sv @@
// Integer literal parser: one character per cycle unless a result stalls, one result per token.
// Request to result: input register, then result register. The default-base multiply-add
// (64 x 5 bits) sets the path; throughput is one character per cycle unless a result stalls.
// Reset (synchronous, active high): clears token state and sets the default base to 10.
// Depends on ilp_pkg.
`timescale 1ns / 1ps

module integer_literal_parser_core (
   input  logic                     clock,
   input  logic                     reset,
   // character requests
   input  logic                     req_valid,
   output logic                     req_stall,
   input  ilp_pkg::req_payload_type req_payload,
   // parse results
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output ilp_pkg::rsp_payload_type rsp_payload,
   // default base register
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [4:0]               csr_data
);

   localparam int unsigned VW = ilp_pkg::VALUE_W;
   localparam int unsigned HW = ilp_pkg::HALF_W;
   localparam int unsigned BW = ilp_pkg::BASE_W;
   localparam int unsigned NP = ilp_pkg::NUM_PATHS;

   // Configuration register
   logic [BW-1:0] base_ff;

   // Input register
   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_char_ff;
   logic          in_last_ff;

   // Token state
   logic [1:0]    char_position_ff, char_position_in;
   logic [7:0]    held_char_ff, held_char_in;
   logic          hex_prefix_seen_ff, hex_prefix_seen_in;
   logic          minus_seen_ff, minus_seen_in;
   logic [VW-1:0] acc_default_ff, acc_default_in;
   logic [VW-1:0] acc_binary_ff, acc_binary_in;
   logic [VW-1:0] acc_octal_ff, acc_octal_in;
   logic [VW-1:0] acc_hex_ff, acc_hex_in;
   logic [NP-1:0] path_valid_ff, path_valid_in;
   logic [NP-1:0] digit_seen_ff, digit_seen_in;

   // Result register
   logic                     rsp_valid_ff, rsp_valid_in;
   ilp_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   // Datapath
   logic          out_free;
   logic          proc_fire;
   logic          req_accept;
   logic [4:0]    digit;
   logic          digit_none;
   logic [3:0]    digit_val;
   logic [7:0]    lower_char;
   logic          def_bad, bin_bad, oct_bad, hex_bad;
   logic [3:0]    def_digit, bin_digit, oct_digit, hex_digit;
   logic [HW+BW-1:0] prod_lo;
   logic [HW-1:0]    prod_hi;
   logic [VW-1:0] acc_def_fold, acc_bin_fold, acc_oct_fold, acc_hex_fold;
   logic          prefix_now, lead_minus;
   logic          res_ok, res_neg;
   logic [VW-1:0] res_val, res_signed;

   // Handshake control
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign proc_fire  = in_valid_ff && (!in_last_ff || out_free);
   assign req_stall  = in_valid_ff && !proc_fire;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign in_valid_in = req_accept | (in_valid_ff & ~proc_fire);

   // Character decode
   assign digit      = ilp_pkg::digit_of(in_char_ff);
   assign digit_none = digit[4];
   assign digit_val  = digit[3:0];
   assign lower_char = ilp_pkg::lower_of(in_char_ff);

   // Per-path digit checks; a bad digit folds in as zero
   assign def_bad   = digit_none || ({1'b0, digit_val} >= base_ff);
   assign bin_bad   = digit_none || (digit_val[3:1] != 3'd0);
   assign oct_bad   = digit_none || digit_val[3];
   assign hex_bad   = digit_none;
   assign def_digit = def_bad ? 4'd0 : digit_val;
   assign bin_digit = bin_bad ? 4'd0 : digit_val;
   assign oct_digit = oct_bad ? 4'd0 : digit_val;
   assign hex_digit = hex_bad ? 4'd0 : digit_val;

   // Default path multiply-add, split in two 32-bit halves
   assign prod_lo = (HW+BW)'(acc_default_ff[HW-1:0]) * (HW+BW)'(base_ff);
   assign prod_hi = HW'(acc_default_ff[VW-1:HW] * HW'(base_ff));
   assign acc_def_fold = VW'(prod_lo) + {prod_hi, {HW{1'b0}}} + VW'(def_digit);

   // Power-of-two paths are shifts
   assign acc_bin_fold = {acc_binary_ff[VW-2:0], 1'b0} | VW'(bin_digit);
   assign acc_oct_fold = {acc_octal_ff[VW-4:0], 3'b000} | VW'(oct_digit);
   assign acc_hex_fold = {acc_hex_ff[VW-5:0], 4'b0000} | VW'(hex_digit);

   // Prefix and sign detection
   assign prefix_now = (char_position_ff == 2'd1) && (held_char_ff == ilp_pkg::CHAR_ZERO) &&
                       (lower_char == ilp_pkg::CHAR_LOWER_X) && !hex_prefix_seen_ff;
   assign lead_minus = (char_position_ff == 2'd0) && (in_char_ff == ilp_pkg::CHAR_MINUS);

   // Token state update and result selection
   always_comb begin
      char_position_in   = char_position_ff;
      held_char_in       = held_char_ff;
      hex_prefix_seen_in = hex_prefix_seen_ff;
      minus_seen_in      = minus_seen_ff;
      acc_default_in     = acc_default_ff;
      acc_binary_in      = acc_binary_ff;
      acc_octal_in       = acc_octal_ff;
      acc_hex_in         = acc_hex_ff;
      path_valid_in      = path_valid_ff;
      digit_seen_in      = digit_seen_ff;
      res_ok             = 1'b0;
      res_val            = '0;
      res_neg            = 1'b0;

      if (base_ff != ilp_pkg::BASE_DECIMAL) begin
         // plain digits in the configured base
         acc_default_in                   = acc_def_fold;
         path_valid_in[ilp_pkg::PATH_DEF] = path_valid_ff[ilp_pkg::PATH_DEF] & ~def_bad;
         digit_seen_in[ilp_pkg::PATH_DEF] = 1'b1;
         res_ok  = path_valid_in[ilp_pkg::PATH_DEF];
         res_val = acc_def_fold;
      end else if (in_last_ff) begin
         // last character: pick the path that the token shape selects
         if (hex_prefix_seen_ff) begin
            res_ok  = path_valid_ff[ilp_pkg::PATH_HEX] & ~hex_bad;
            res_val = acc_hex_fold;
         end else if (prefix_now) begin
            res_ok = 1'b0;
         end else if (lower_char == ilp_pkg::CHAR_LOWER_B) begin
            res_ok  = path_valid_ff[ilp_pkg::PATH_BIN] & digit_seen_ff[ilp_pkg::PATH_BIN];
            res_val = acc_binary_ff;
            res_neg = minus_seen_ff;
         end else if (lower_char == ilp_pkg::CHAR_LOWER_O) begin
            res_ok  = path_valid_ff[ilp_pkg::PATH_OCT] & digit_seen_ff[ilp_pkg::PATH_OCT];
            res_val = acc_octal_ff;
            res_neg = minus_seen_ff;
         end else if (lower_char == ilp_pkg::CHAR_LOWER_H) begin
            res_ok  = path_valid_ff[ilp_pkg::PATH_HEX] & digit_seen_ff[ilp_pkg::PATH_HEX];
            res_val = acc_hex_ff;
            res_neg = minus_seen_ff;
         end else if (lead_minus) begin
            res_ok = 1'b0;
         end else begin
            res_ok  = path_valid_ff[ilp_pkg::PATH_DEF] & ~def_bad;
            res_val = acc_def_fold;
            res_neg = minus_seen_ff;
         end
      end else if (prefix_now) begin
         // "0x" restarts the hex path
         hex_prefix_seen_in               = 1'b1;
         acc_hex_in                       = '0;
         path_valid_in[ilp_pkg::PATH_HEX] = 1'b1;
         digit_seen_in[ilp_pkg::PATH_HEX] = 1'b0;
      end else if (lead_minus) begin
         minus_seen_in = 1'b1;
      end else begin
         // feed all four paths
         acc_default_in = acc_def_fold;
         acc_binary_in  = acc_bin_fold;
         acc_octal_in   = acc_oct_fold;
         acc_hex_in     = acc_hex_fold;
         path_valid_in  = path_valid_ff & ~{hex_bad, oct_bad, bin_bad, def_bad};
         digit_seen_in  = {NP{1'b1}};
      end

      // first character is held for prefix detection
      if (char_position_ff == 2'd0) begin
         held_char_in = in_char_ff;
      end

      if (in_last_ff) begin
         // token done: back to token reset values
         char_position_in   = 2'd0;
         held_char_in       = 8'd0;
         hex_prefix_seen_in = 1'b0;
         minus_seen_in      = 1'b0;
         acc_default_in     = '0;
         acc_binary_in      = '0;
         acc_octal_in       = '0;
         acc_hex_in         = '0;
         path_valid_in      = {NP{1'b1}};
         digit_seen_in      = '0;
      end else if (char_position_ff != 2'd2) begin
         char_position_in = char_position_ff + 2'd1;
      end
   end

   // Sign and invalid-token masking
   assign res_signed = res_neg ? (VW'(0) - res_val) : res_val;

   always_comb begin
      rsp_payload_in.parse_ok     = res_ok;
      rsp_payload_in.parsed_value = res_ok ? res_signed : '0;
   end

   // Result register next state
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (proc_fire && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff            <= ilp_pkg::BASE_DECIMAL;
         in_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         char_position_ff   <= 2'd0;
         held_char_ff       <= 8'd0;
         hex_prefix_seen_ff <= 1'b0;
         minus_seen_ff      <= 1'b0;
         acc_default_ff     <= '0;
         acc_binary_ff      <= '0;
         acc_octal_ff       <= '0;
         acc_hex_ff         <= '0;
         path_valid_ff      <= {NP{1'b1}};
         digit_seen_ff      <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            base_ff <= csr_data;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (proc_fire) begin
            char_position_ff   <= char_position_in;
            held_char_ff       <= held_char_in;
            hex_prefix_seen_ff <= hex_prefix_seen_in;
            minus_seen_ff      <= minus_seen_in;
            acc_default_ff     <= acc_default_in;
            acc_binary_ff      <= acc_binary_in;
            acc_octal_ff       <= acc_octal_in;
            acc_hex_ff         <= acc_hex_in;
            path_valid_ff      <= path_valid_in;
            digit_seen_ff      <= digit_seen_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_char_ff <= req_payload.char_in;
         in_last_ff <= req_payload.last_char;
      end
      if (proc_fire && in_last_ff) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

@@ rtl/core/ilp_checker.sv @@
// Port-level checker for the integer literal parser core, bound to the core module.
// Depends on ilp_pkg and integer_literal_parser_core.
`timescale 1ns / 1ps

module ilp_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input ilp_pkg::req_payload_type req_payload,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input ilp_pkg::rsp_payload_type rsp_payload
);

   // A stalled request is still offered, unchanged, at the next edge
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_payload))
      else $error("stalled request changed");

   // A stalled result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // A rejected token reports a zero value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.parse_ok |-> rsp_payload.parsed_value == 64'd0)
      else $error("invalid token with nonzero value");

   // Requests back up only behind a stalled result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without result backpressure");

   // Out of reset the core takes requests and shows no result
   assert property (@(posedge clock)
      reset |=> !req_stall && !rsp_valid)
      else $error("core not idle after reset");

endmodule

bind integer_literal_parser_core ilp_checker u_ilp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
